// ===== rtl/six_axis_force_torque_calibration_macros.svh =====
`ifndef SIX_AXIS_FORCE_TORQUE_CALIBRATION_MACROS_SVH
`define SIX_AXIS_FORCE_TORQUE_CALIBRATION_MACROS_SVH

// same-cycle implication, sampled on clk, off during rst
`define FTC_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ftc: assertion failed");

// next-cycle implication, sampled on clk, off during rst
`define FTC_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ftc: assertion failed");

`endif

// ===== rtl/ftc_pkg.sv =====
package ftc_pkg;

  localparam int CHANNELS = 6;
  localparam int AXES     = 6;
  localparam int IDX_W    = 6;
  localparam int MTX_N    = CHANNELS * CHANNELS;
  localparam int MTX_AW   = (MTX_N > 1) ? $clog2(MTX_N) : 1;
  localparam int COL_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int PROD_W   = 32;
  localparam int ACC_W    = PROD_W + COL_W + 1;
  localparam int SAT_W    = 40;
  localparam int PC_W     = 4;

  typedef logic signed [15:0] q15_t;

  localparam logic [2:0] KIND_CONVERT  = 3'd0;
  localparam logic [2:0] KIND_LOAD_MTX = 3'd1;
  localparam logic [2:0] KIND_LOAD_OFS = 3'd2;
  localparam logic [2:0] KIND_SET_TARE = 3'd3;
  localparam logic [2:0] KIND_CAPTURE  = 3'd4;
  localparam logic [2:0] KIND_CLEAR    = 3'd5;

  // microprogram addresses
  localparam logic [PC_W-1:0] PC_IDLE       = 4'd0;
  localparam logic [PC_W-1:0] PC_CONV_PREP  = 4'd1;
  localparam logic [PC_W-1:0] PC_CONV_MAC   = 4'd2;
  localparam logic [PC_W-1:0] PC_CONV_DRAIN = 4'd3;
  localparam logic [PC_W-1:0] PC_CONV_WAIT  = 4'd4;
  localparam logic [PC_W-1:0] PC_CONV_OUT   = 4'd5;
  localparam logic [PC_W-1:0] PC_CAP_PREP   = 4'd6;
  localparam logic [PC_W-1:0] PC_CAP_MAC    = 4'd7;
  localparam logic [PC_W-1:0] PC_CAP_DRAIN  = 4'd8;
  localparam logic [PC_W-1:0] PC_CAP_APPLY  = 4'd9;
  localparam logic [PC_W-1:0] PC_LD_MTX     = 4'd10;
  localparam logic [PC_W-1:0] PC_LD_OFS     = 4'd11;
  localparam logic [PC_W-1:0] PC_SET_TARE   = 4'd12;
  localparam logic [PC_W-1:0] PC_CLR_TARE   = 4'd13;
  localparam logic [PC_W-1:0] PC_SKIP       = 4'd14;

  typedef enum logic [3:0] {
    OP_NOP      = 4'd0,
    OP_PREP     = 4'd1,
    OP_MAC      = 4'd2,
    OP_OUT      = 4'd3,
    OP_CAPT     = 4'd4,
    OP_LD_MTX   = 4'd5,
    OP_LD_OFS   = 4'd6,
    OP_SET_TARE = 4'd7,
    OP_CLR_TARE = 4'd8
  } uop_t;

  typedef enum logic [2:0] {
    J_NEXT      = 3'd0,
    J_GOTO      = 3'd1,
    J_DISPATCH  = 3'd2,
    J_MAC_LOOP  = 3'd3,
    J_PIPE_WAIT = 3'd4,
    J_OUT_WAIT  = 3'd5
  } jmp_t;

  typedef struct packed {
    uop_t            op;
    jmp_t            jmp;
    logic [PC_W-1:0] target;
    logic            done;
  } uword_t;

  typedef struct packed {
    logic mac_last;
    logic pipe_busy;
    logic out_busy;
  } dp_status_t;

  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    unique case (pc)
      PC_IDLE:       w = '{op: OP_NOP,      jmp: J_DISPATCH,  target: PC_IDLE, done: 1'b0};
      PC_CONV_PREP:  w = '{op: OP_PREP,     jmp: J_NEXT,      target: PC_IDLE, done: 1'b0};
      PC_CONV_MAC:   w = '{op: OP_MAC,      jmp: J_MAC_LOOP,  target: PC_IDLE, done: 1'b0};
      PC_CONV_DRAIN: w = '{op: OP_NOP,      jmp: J_PIPE_WAIT, target: PC_IDLE, done: 1'b0};
      PC_CONV_WAIT:  w = '{op: OP_NOP,      jmp: J_OUT_WAIT,  target: PC_IDLE, done: 1'b0};
      PC_CONV_OUT:   w = '{op: OP_OUT,      jmp: J_GOTO,      target: PC_IDLE, done: 1'b1};
      PC_CAP_PREP:   w = '{op: OP_PREP,     jmp: J_NEXT,      target: PC_IDLE, done: 1'b0};
      PC_CAP_MAC:    w = '{op: OP_MAC,      jmp: J_MAC_LOOP,  target: PC_IDLE, done: 1'b0};
      PC_CAP_DRAIN:  w = '{op: OP_NOP,      jmp: J_PIPE_WAIT, target: PC_IDLE, done: 1'b0};
      PC_CAP_APPLY:  w = '{op: OP_CAPT,     jmp: J_GOTO,      target: PC_IDLE, done: 1'b1};
      PC_LD_MTX:     w = '{op: OP_LD_MTX,   jmp: J_GOTO,      target: PC_IDLE, done: 1'b1};
      PC_LD_OFS:     w = '{op: OP_LD_OFS,   jmp: J_GOTO,      target: PC_IDLE, done: 1'b1};
      PC_SET_TARE:   w = '{op: OP_SET_TARE, jmp: J_GOTO,      target: PC_IDLE, done: 1'b1};
      PC_CLR_TARE:   w = '{op: OP_CLR_TARE, jmp: J_GOTO,      target: PC_IDLE, done: 1'b1};
      PC_SKIP:       w = '{op: OP_NOP,      jmp: J_GOTO,      target: PC_IDLE, done: 1'b1};
      default:       w = '{op: OP_NOP,      jmp: J_GOTO,      target: PC_IDLE, done: 1'b0};
    endcase
    return w;
  endfunction

  function automatic logic [PC_W-1:0] dispatch(input logic [2:0] kind);
    logic [PC_W-1:0] pc;
    unique case (kind)
      KIND_CONVERT:  pc = PC_CONV_PREP;
      KIND_LOAD_MTX: pc = PC_LD_MTX;
      KIND_LOAD_OFS: pc = PC_LD_OFS;
      KIND_SET_TARE: pc = PC_SET_TARE;
      KIND_CAPTURE:  pc = PC_CAP_PREP;
      KIND_CLEAR:    pc = PC_CLR_TARE;
      default:       pc = PC_SKIP;
    endcase
    return pc;
  endfunction

  function automatic q15_t sat16(input logic signed [SAT_W-1:0] v);
    q15_t r;
    if (v > SAT_W'(32767)) begin
      r = 16'sh7fff;
    end else if (v < SAT_W'(-32768)) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/ftc_seq.sv =====
`include "six_axis_force_torque_calibration_macros.svh"

module ftc_seq
  import ftc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       item_v,
  input  logic [2:0] kind,
  input  dp_status_t st,
  output uword_t     cw
);

  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] pc_next;

  assign cw = ucode(pc);

  always_comb begin
    unique case (cw.jmp)
      J_NEXT:      pc_next = pc + PC_W'(1);
      J_GOTO:      pc_next = cw.target;
      J_DISPATCH:  pc_next = item_v ? dispatch(kind) : pc;
      J_MAC_LOOP:  pc_next = st.mac_last ? pc + PC_W'(1) : pc;
      J_PIPE_WAIT: pc_next = st.pipe_busy ? pc : pc + PC_W'(1);
      J_OUT_WAIT:  pc_next = st.out_busy ? pc : pc + PC_W'(1);
      default:     pc_next = PC_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= PC_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

  `FTC_ASSERT_IMP(a_done_has_item, cw.done, item_v)
  `FTC_ASSERT_NXT(a_mac_loop_holds, cw.op == OP_MAC && !st.mac_last, cw.op == OP_MAC)

endmodule

// ===== rtl/ftc_dp.sv =====
`include "six_axis_force_torque_calibration_macros.svh"

module ftc_dp
  import ftc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  uop_t             op,
  input  logic [IDX_W-1:0] entry_index,
  input  q15_t             load_value,
  input  q15_t             sample [AXES],
  input  logic             result_stall,
  output logic             result_valid,
  output q15_t             res [AXES],
  output dp_status_t       st
);

  q15_t mtx_mem [MTX_N];
  q15_t ofs  [CHANNELS];
  q15_t tare [CHANNELS];
  q15_t x    [CHANNELS];
  q15_t y    [CHANNELS];

  logic [MTX_AW-1:0] addr;
  logic [COL_W-1:0]  col;
  logic [COL_W-1:0]  row;
  logic              mac_last;
  logic              col_last;

  logic              rd_v;
  q15_t              rd_data;
  logic [COL_W-1:0]  rd_col;
  logic [COL_W-1:0]  rd_row;
  logic              rd_first;
  logic              rd_last;

  logic                     prod_v;
  logic signed [PROD_W-1:0] prod;
  logic [COL_W-1:0]         prod_row;
  logic                     prod_first;
  logic                     prod_last;

  logic signed [ACC_W-1:0] acc;
  logic                    fin_v;
  logic [COL_W-1:0]        fin_row;
  logic signed [SAT_W-1:0] acc_bias;

  logic mtx_wr_ok;
  logic ch_wr_ok;

  assign mac_last  = addr == MTX_AW'(MTX_N - 1);
  assign col_last  = col == COL_W'(CHANNELS - 1);
  assign mtx_wr_ok = entry_index < IDX_W'(MTX_N);
  assign ch_wr_ok  = entry_index < IDX_W'(CHANNELS);
  // floor((acc + 2^14) / 2^15)
  assign acc_bias  = SAT_W'(acc) + SAT_W'(16384);

  assign st.mac_last  = mac_last;
  assign st.pipe_busy = rd_v | prod_v | fin_v;
  assign st.out_busy  = result_valid & result_stall;

  always_ff @(posedge clk) begin
    if (op == OP_LD_MTX && mtx_wr_ok) begin
      mtx_mem[entry_index[MTX_AW-1:0]] <= load_value;
    end
    rd_data <= mtx_mem[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v   <= 1'b0;
      prod_v <= 1'b0;
      fin_v  <= 1'b0;
    end else begin
      rd_v   <= op == OP_MAC;
      prod_v <= rd_v;
      fin_v  <= prod_v & prod_last;
    end
  end

  // MAC pipeline: matrix read, multiply, accumulate, round
  always_ff @(posedge clk) begin
    if (op == OP_PREP) begin
      addr <= '0;
      col  <= '0;
      row  <= '0;
      for (int c = 0; c < CHANNELS; c++) begin
        x[c] <= sat16(SAT_W'(sample[c]) + SAT_W'(ofs[c]));
      end
    end else if (op == OP_MAC) begin
      addr <= mac_last ? addr : addr + MTX_AW'(1);
      if (col_last) begin
        col <= '0;
        row <= row + COL_W'(1);
      end else begin
        col <= col + COL_W'(1);
      end
    end
    rd_col   <= col;
    rd_row   <= row;
    rd_first <= col == '0;
    rd_last  <= col_last;

    prod       <= rd_data * x[rd_col];
    prod_row   <= rd_row;
    prod_first <= rd_first;
    prod_last  <= rd_last;

    if (prod_v) begin
      acc <= prod_first ? ACC_W'(prod) : acc + ACC_W'(prod);
    end
    fin_row <= prod_row;

    if (fin_v) begin
      y[fin_row] <= sat16(acc_bias >>> 15);
    end

    if (op == OP_LD_OFS && ch_wr_ok) begin
      ofs[entry_index[COL_W-1:0]] <= load_value;
    end

    if (op == OP_OUT) begin
      for (int r = 0; r < CHANNELS; r++) begin
        res[r] <= sat16(SAT_W'(y[r]) + SAT_W'(tare[r]));
      end
      for (int r = CHANNELS; r < AXES; r++) begin
        res[r] <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < CHANNELS; r++) begin
        tare[r] <= '0;
      end
    end else begin
      unique case (op)
        OP_SET_TARE: begin
          if (ch_wr_ok) begin
            tare[entry_index[COL_W-1:0]] <= load_value;
          end
        end
        OP_CLR_TARE: begin
          for (int r = 0; r < CHANNELS; r++) begin
            tare[r] <= '0;
          end
        end
        OP_CAPT: begin
          for (int r = 0; r < CHANNELS; r++) begin
            tare[r] <= sat16(-SAT_W'(y[r]));
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (op == OP_OUT) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  `FTC_ASSERT_IMP(a_out_not_blocked, op == OP_OUT, !(result_valid && result_stall))
  `FTC_ASSERT_IMP(a_apply_after_drain, op == OP_OUT || op == OP_CAPT, !st.pipe_busy)

endmodule

// ===== rtl/six_axis_force_torque_calibration.sv =====
// Six-axis force/torque calibration.
// Input channel (sample_valid / sample_stall): one beat carries kind, entry_index,
// load_value and six raw Q15 strain samples. sample_stall is high while an item is
// being worked on; the block takes one item at a time.
// Output channel (result_valid / result_stall): a convert beat yields one result
// beat of six Q15 values; all other kinds yield none.
// Convert and capture-tare run 36 multiply-accumulates through the single multiplier
// and matrix read port, then drain the pipeline; a convert then writes the result
// register, a capture-tare writes the tare entries. The next item is taken once the
// current one is done. Loads and set/clear tare skip the multiply-accumulate loop.
// A held result does not block the next item; a following convert waits before
// writing the result register until the previous beat is taken.
// Reset clears the sequencer, the handshakes and all tare entries; matrix and
// calibration offsets hold nothing defined until loaded.
module six_axis_force_torque_calibration
  import ftc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             sample_valid,
  output logic             sample_stall,
  input  logic [2:0]       kind,
  input  logic [IDX_W-1:0] entry_index,
  input  q15_t             load_value,
  input  q15_t             sample_ch0,
  input  q15_t             sample_ch1,
  input  q15_t             sample_ch2,
  input  q15_t             sample_ch3,
  input  q15_t             sample_ch4,
  input  q15_t             sample_ch5,
  output logic             result_valid,
  input  logic             result_stall,
  output q15_t             force_0,
  output q15_t             force_1,
  output q15_t             force_2,
  output q15_t             torque_0,
  output q15_t             torque_1,
  output q15_t             torque_2
);

  logic             item_v;
  logic [2:0]       kind_q;
  logic [IDX_W-1:0] idx_q;
  q15_t             val_q;
  q15_t             samp_q [AXES];
  q15_t             res    [AXES];
  logic             accept;
  uword_t           cw;
  dp_status_t       st;

  assign sample_stall = item_v;
  assign accept       = sample_valid & ~item_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_v <= 1'b0;
    end else if (accept) begin
      item_v <= 1'b1;
    end else if (cw.done) begin
      item_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_q    <= kind;
      idx_q     <= entry_index;
      val_q     <= load_value;
      samp_q[0] <= sample_ch0;
      samp_q[1] <= sample_ch1;
      samp_q[2] <= sample_ch2;
      samp_q[3] <= sample_ch3;
      samp_q[4] <= sample_ch4;
      samp_q[5] <= sample_ch5;
    end
  end

  ftc_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .item_v (item_v),
    .kind   (kind_q),
    .st     (st),
    .cw     (cw)
  );

  ftc_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .op           (cw.op),
    .entry_index  (idx_q),
    .load_value   (val_q),
    .sample       (samp_q),
    .result_stall (result_stall),
    .result_valid (result_valid),
    .res          (res),
    .st           (st)
  );

  assign force_0  = res[0];
  assign force_1  = res[1];
  assign force_2  = res[2];
  assign torque_0 = res[3];
  assign torque_1 = res[4];
  assign torque_2 = res[5];

endmodule
